// ===== rtl/sqlq_pkg.sv =====
// Shared types, character codes and keyword table for the query lexer.
// No dependencies; imported by sql_query_lexer.
package sqlq_pkg;

  localparam int POS_W    = 16;
  localparam int LEN_W    = 8;
  localparam int WORD_BUF = 6;
  localparam int NUM_KW   = 10;
  localparam logic [LEN_W-1:0] MAX_TOKEN_LEN = 8'd255;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_GT,
    MODE_LT,
    MODE_ERR
  } lex_mode_t;

  typedef enum logic [4:0] {
    KIND_IDENT, KIND_INT,
    KIND_FROM, KIND_ORDER, KIND_BY, KIND_WHERE, KIND_SELECT,
    KIND_AND, KIND_OR, KIND_DELETE, KIND_HAVING, KIND_UPDATE,
    KIND_OPEN, KIND_CLOSE, KIND_GT, KIND_LT, KIND_GTE, KIND_LTE,
    KIND_SEMI, KIND_PLUS, KIND_STAR, KIND_MINUS, KIND_SLASH, KIND_COMMA,
    KIND_ERROR
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t        kind;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] length;
    logic [1:0]       prec;
    logic             last;
  } tok_t;

  typedef logic [WORD_BUF-1:0][7:0] word_buf_t;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // first character in the top byte; padding is never compared
  localparam logic [8*WORD_BUF-1:0] KW_TEXT [NUM_KW] = '{
    "from  ", "order ", "by    ", "where ", "select",
    "and   ", "or    ", "delete", "having", "update"
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd4, 3'd5, 3'd2, 3'd5, 3'd6, 3'd3, 3'd2, 3'd6, 3'd6, 3'd6
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic tok_kind_t word_kind(input word_buf_t w, input logic [LEN_W-1:0] len);
    tok_kind_t k;
    logic      hit;
    k = KIND_IDENT;
    for (int j = 0; j < NUM_KW; j++) begin
      hit = (len == LEN_W'(KW_LEN[j]));
      for (int i = 0; i < WORD_BUF; i++) begin
        if (i < int'(KW_LEN[j]) && w[i] != KW_TEXT[j][8*WORD_BUF-1-8*i -: 8])
          hit = 1'b0;
      end
      if (hit)
        k = tok_kind_t'(5'(KIND_FROM) + 5'(j));
    end
    return k;
  endfunction

  function automatic logic [1:0] prec_of(input tok_kind_t k);
    logic [1:0] p;
    unique case (k)
      KIND_MINUS, KIND_PLUS, KIND_GT, KIND_LT, KIND_GTE, KIND_LTE,
      KIND_AND, KIND_OR:       p = 2'd0;
      KIND_SLASH, KIND_STAR:   p = 2'd1;
      default:                 p = 2'd2;
    endcase
    return p;
  endfunction

  function automatic tok_t make_tok(input tok_kind_t k, input logic [POS_W-1:0] s,
                                    input logic [LEN_W-1:0] l);
    tok_t t;
    t.kind   = k;
    t.start  = s;
    t.length = l;
    t.prec   = prec_of(k);
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

// ===== rtl/sql_query_lexer.sv =====
// Streaming query lexer: one character word in, up to two token words out.
// Depends on sqlq_pkg (types, keyword table, character classes).
//
//  channel | handshake          | payload
//  in_     | in_valid/in_ready  | ch[7:0], end_of_text
//  out_    | out_valid/out_ready| token_kind[4:0], token_start[15:0],
//          |                    | token_length[7:0], precedence[1:0], last_of_run
//
// One character per cycle; tokens are formed in the accepting cycle and land in a
// two-word result buffer. A character giving two tokens holds in_ready low until the
// first of them is taken. in_ready also drops while out_ready stalls a buffered
// token. Reset (rst_n low, synchronous) returns to idle at offset zero.
module sql_query_lexer
  import sqlq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_ch,
  input  logic             in_end_of_text,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [4:0]       out_token_kind,
  output logic [POS_W-1:0] out_token_start,
  output logic [LEN_W-1:0] out_token_length,
  output logic [1:0]       out_precedence,
  output logic             out_last_of_run
);

  lex_mode_t        mode_r, mode_nxt;
  word_buf_t        word_r, word_nxt;
  logic [LEN_W-1:0] wlen_r, wlen_nxt;
  logic [POS_W-1:0] begin_r, begin_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  tok_t             q0_r, q1_r, q0_nxt, q1_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  tok_t             t0, t1;
  logic [1:0]       n;

  logic             acc, pop;

  assign acc = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  assign in_ready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign out_valid = (cnt_r != 2'd0);

  assign out_token_kind   = q0_r.kind;
  assign out_token_start  = q0_r.start;
  assign out_token_length = q0_r.length;
  assign out_precedence   = q0_r.prec;
  assign out_last_of_run  = q0_r.last;

  // lexing of one character against the current state
  always_comb begin
    tok_t      e;
    logic      used;
    tok_kind_t pk;
    mode_nxt  = mode_r;
    word_nxt  = word_r;
    wlen_nxt  = wlen_r;
    begin_nxt = begin_r;
    pos_nxt   = pos_r + POS_W'(1);
    t0        = '0;
    t1        = '0;
    n         = 2'd0;
    used      = 1'b0;
    e         = '0;
    pk        = KIND_ERROR;

    if (mode_r == MODE_ERR) begin
      if (in_end_of_text) begin
        mode_nxt = MODE_IDLE;
        pos_nxt  = '0;
        wlen_nxt = '0;
      end
    end else begin
      // continue or close the pending token
      if ((mode_r == MODE_WORD && (is_letter(in_ch) || is_digit(in_ch))) ||
          (mode_r == MODE_NUM && is_digit(in_ch))) begin
        for (int i = 0; i < WORD_BUF; i++)
          if (wlen_r == LEN_W'(i)) word_nxt[i] = in_ch;
        if (wlen_r < MAX_TOKEN_LEN) wlen_nxt = wlen_r + LEN_W'(1);
        used = 1'b1;
      end else if ((mode_r == MODE_GT || mode_r == MODE_LT) && in_ch == CH_EQ) begin
        t0       = make_tok((mode_r == MODE_GT) ? KIND_GTE : KIND_LTE, begin_r, LEN_W'(2));
        n        = 2'd1;
        mode_nxt = MODE_IDLE;
        used     = 1'b1;
      end else begin
        unique case (mode_r)
          MODE_WORD: begin
            t0 = make_tok(word_kind(word_r, wlen_r), begin_r, wlen_r);
            n  = 2'd1;
          end
          MODE_NUM: begin
            t0 = make_tok(KIND_INT, begin_r, wlen_r);
            n  = 2'd1;
          end
          MODE_GT: begin
            t0 = make_tok(KIND_GT, begin_r, LEN_W'(1));
            n  = 2'd1;
          end
          MODE_LT: begin
            t0 = make_tok(KIND_LT, begin_r, LEN_W'(1));
            n  = 2'd1;
          end
          default: ;
        endcase
        mode_nxt = MODE_IDLE;
      end

      // character not absorbed: lex it from idle
      if (!used) begin
        if (is_letter(in_ch) || is_digit(in_ch)) begin
          mode_nxt    = is_letter(in_ch) ? MODE_WORD : MODE_NUM;
          begin_nxt   = pos_r;
          word_nxt[0] = in_ch;
          wlen_nxt    = LEN_W'(1);
        end else if (in_ch == CH_GT || in_ch == CH_LT) begin
          mode_nxt  = (in_ch == CH_GT) ? MODE_GT : MODE_LT;
          begin_nxt = pos_r;
        end else if (!is_space(in_ch)) begin
          case (in_ch)
            CH_LPAREN: pk = KIND_OPEN;
            CH_RPAREN: pk = KIND_CLOSE;
            CH_SEMI:   pk = KIND_SEMI;
            CH_PLUS:   pk = KIND_PLUS;
            CH_STAR:   pk = KIND_STAR;
            CH_MINUS:  pk = KIND_MINUS;
            CH_SLASH:  pk = KIND_SLASH;
            CH_COMMA:  pk = KIND_COMMA;
            default: begin
              pk       = KIND_ERROR;
              mode_nxt = MODE_ERR;
            end
          endcase
          e = make_tok(pk, pos_r, LEN_W'(1));
          if (n == 2'd0) t0 = e;
          else           t1 = e;
          n = n + 2'd1;
        end
      end

      // end mark: flush whatever is now pending
      if (in_end_of_text) begin
        e = '0;
        unique case (mode_nxt)
          MODE_WORD: e = make_tok(word_kind(word_nxt, wlen_nxt), begin_nxt, wlen_nxt);
          MODE_NUM:  e = make_tok(KIND_INT, begin_nxt, wlen_nxt);
          MODE_GT:   e = make_tok(KIND_GT, begin_nxt, LEN_W'(1));
          MODE_LT:   e = make_tok(KIND_LT, begin_nxt, LEN_W'(1));
          default: ;
        endcase
        if (mode_nxt == MODE_WORD || mode_nxt == MODE_NUM ||
            mode_nxt == MODE_GT || mode_nxt == MODE_LT) begin
          if (n == 2'd0) t0 = e;
          else           t1 = e;
          n = n + 2'd1;
        end
        mode_nxt = MODE_IDLE;
        pos_nxt  = '0;
        wlen_nxt = '0;
      end
    end

    if (n == 2'd1) t0.last = 1'b1;
    if (n == 2'd2) t1.last = 1'b1;
  end

  // result buffer: q0 is the head word
  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    if (acc) begin
      q0_nxt  = t0;
      q1_nxt  = t1;
      cnt_nxt = n;
    end else if (pop) begin
      q0_nxt  = q1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (acc) begin
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= '0;
      begin_r <= '0;
      pos_r   <= '0;
      cnt_r   <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        wlen_r  <= wlen_nxt;
        begin_r <= begin_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
    if (acc) word_r <= word_nxt;
  end

`ifndef NO_ASSERTIONS
  a_eot_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_end_of_text |=> pos_r == '0 && mode_r == MODE_IDLE)
    else $error("end mark did not return lexer to idle at offset zero");

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && mode_r == MODE_ERR |=> cnt_r == 2'd0)
    else $error("token produced while skipping after an illegal character");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_ready)
    else $error("input accepted with result buffer full");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> cnt_r == 2'd2 && q1_r.last)
    else $error("first token of a pair without its closing token behind it");

  a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_ERROR |-> out_token_length == LEN_W'(1))
    else $error("error token length is not one");
`endif

endmodule
